// ----- hdl/edit_distance_engine_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the edit distance engine
// Concurrent assertion shorthands, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef EDIT_DISTANCE_ENGINE_ASSERT_SVH
`define EDIT_DISTANCE_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define EDI_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("edit distance engine: assertion failed");

`define EDI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("edit distance engine: assertion failed");

`else

`define EDI_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define EDI_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/edi_pkg.sv -----
// ----------------------------------------------------------------------------
// Edit distance engine package
// Command codes and the control group broadcast to the cell chain.
// ----------------------------------------------------------------------------
package edi_pkg;

  localparam int CHAR_W = 8;
  localparam int DIST_W = 5;

  typedef enum logic [1:0] {
    OP_CLEAR      = 2'd0,
    OP_APPEND_REF = 2'd1,
    OP_APPEND_QRY = 2'd2,
    OP_FINISH     = 2'd3
  } op_t;

  typedef struct packed {
    logic              restore;
    logic              ref_we;
    logic [CHAR_W-1:0] ref_char;
  } ctrl_t;

endpackage

// ----- hdl/edi_cell.sv -----
// ----------------------------------------------------------------------------
// Edit distance cell
// Holds one reference byte and one entry of the distance column, and updates
// the entry as a query wavefront passes, handing it on to the next cell.
// ----------------------------------------------------------------------------
module edi_cell #(
  parameter int DP_W = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  edi_pkg::ctrl_t                ctrl,
  input  logic [DP_W-1:0]               cell_idx,
  input  logic [DP_W-1:0]               ref_len,
  input  logic                          wv_vld_i,
  input  logic [edi_pkg::CHAR_W-1:0]    wv_ch_i,
  input  logic [DP_W-1:0]               wv_left_i,
  input  logic [DP_W-1:0]               wv_diag_i,
  output logic                          wv_vld_o,
  output logic [edi_pkg::CHAR_W-1:0]    wv_ch_o,
  output logic [DP_W-1:0]               wv_left_o,
  output logic [DP_W-1:0]               wv_diag_o
);
  import edi_pkg::*;

  logic [CHAR_W-1:0] ref_ch_r;
  logic [DP_W-1:0]   dp_r, dp_nxt;
  logic              vld_r;
  logic [CHAR_W-1:0] ch_r;
  logic [DP_W-1:0]   left_r, left_nxt;
  logic [DP_W-1:0]   diag_r;
  logic              active;
  logic              ref_hit;
  logic [DP_W:0]     above_inc, left_inc, diag_inc, min_ab, min_all;
  logic [DP_W-1:0]   cand;

  always_comb begin
    active    = (cell_idx <= ref_len);
    ref_hit   = ctrl.ref_we && ({1'b0, cell_idx} == ({1'b0, ref_len} + 1'b1));
    above_inc = {1'b0, dp_r} + 1'b1;
    left_inc  = {1'b0, wv_left_i} + 1'b1;
    diag_inc  = {1'b0, wv_diag_i} + 1'b1;
    min_ab    = (left_inc < above_inc) ? left_inc : above_inc;
    min_all   = (diag_inc < min_ab) ? diag_inc : min_ab;
    if (ref_ch_r == wv_ch_i) begin
      cand = wv_diag_i;
    end else begin
      cand = min_all[DP_W-1:0];
    end
    left_nxt = active ? cand : wv_left_i;
    if (ctrl.restore) begin
      dp_nxt = cell_idx;
    end else if (wv_vld_i && active) begin
      dp_nxt = cand;
    end else begin
      dp_nxt = dp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dp_r  <= cell_idx;
      vld_r <= 1'b0;
    end else begin
      dp_r  <= dp_nxt;
      vld_r <= wv_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ref_hit) begin
      ref_ch_r <= ctrl.ref_char;
    end
    ch_r   <= wv_ch_i;
    left_r <= left_nxt;
    diag_r <= dp_r;
  end

  assign wv_vld_o  = vld_r;
  assign wv_ch_o   = ch_r;
  assign wv_left_o = left_r;
  assign wv_diag_o = diag_r;

endmodule

// ----- hdl/edit_distance_engine.sv -----
// ----------------------------------------------------------------------------
// Edit distance engine
// Levenshtein distance between a stored reference string and a query string,
// computed by a chain of cells, one for each reference position.
// ----------------------------------------------------------------------------
// Commands are transferred on in_opcode and in_char_in at a clock edge where
// start is high and busy is low. Opcode 0 clears everything, 1 appends a
// reference byte, 2 appends a query byte and 3 finishes the query.
// Clear, reference append, finish and a dropped query byte do not raise busy.
// A query byte that is kept sends a wavefront down the cell chain, one
// cell per cycle, and busy stays high until the wavefront has left the last
// cell, so no further command is taken while it runs. The length of the cell
// chain alone sets how long this lasts.
// A finish gives one result on out_distance and out_overflow, marked by
// out_valid in the cycle after its transfer. The receiver cannot stall, so
// the result is present for that single cycle only.
// Bytes beyond MAX_LEN are dropped and set the sticky overflow flag, which
// only a clear or a reset resets. Reset empties the reference and the query,
// restores the distance column and clears the overflow flag; it takes effect
// at the first clock edge with rst_n low.
// ----------------------------------------------------------------------------
`include "edit_distance_engine_assert.svh"

module edit_distance_engine #(
  parameter int MAX_LEN = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_opcode,
  input  logic [edi_pkg::CHAR_W-1:0]    in_char_in,
  output logic                          out_valid,
  output logic [edi_pkg::DIST_W-1:0]    out_distance,
  output logic                          out_overflow
);
  import edi_pkg::*;

  localparam int DP_W = ($clog2(MAX_LEN + 1) > DIST_W) ? $clog2(MAX_LEN + 1) : DIST_W;

  op_t              op;
  logic             accept;
  ctrl_t            ctrl;
  logic [DP_W-1:0]  ref_len_r, ref_len_nxt;
  logic [DP_W-1:0]  qcount_r, qcount_nxt;
  logic             ovf_r, ovf_nxt;
  logic [DP_W-1:0]  dist_r, dist_nxt;
  logic             launch;
  logic             out_valid_r;
  logic [DIST_W-1:0] out_distance_r;
  logic             out_overflow_r;

  logic [MAX_LEN:0] wv_vld;
  logic [CHAR_W-1:0] wv_ch   [MAX_LEN+1];
  logic [DP_W-1:0]   wv_left [MAX_LEN+1];
  logic [DP_W-1:0]   wv_diag [MAX_LEN+1];
  logic              wv0_vld_r;
  logic [CHAR_W-1:0] wv0_ch_r;
  logic [DP_W-1:0]   wv0_left_r;
  logic [DP_W-1:0]   wv0_diag_r;

  assign op     = op_t'(in_opcode);
  assign busy   = |wv_vld;
  assign accept = start && !busy;

  always_comb begin
    ctrl.restore  = accept && ((op == OP_CLEAR) || (op == OP_FINISH));
    ctrl.ref_we   = accept && (op == OP_APPEND_REF) && (qcount_r == '0)
                    && (ref_len_r != DP_W'(MAX_LEN));
    ctrl.ref_char = in_char_in;
    launch        = accept && (op == OP_APPEND_QRY) && (qcount_r != DP_W'(MAX_LEN));
    ref_len_nxt   = ref_len_r;
    qcount_nxt    = qcount_r;
    ovf_nxt       = ovf_r;
    dist_nxt      = dist_r;
    if (wv_vld[MAX_LEN]) begin
      dist_nxt = wv_left[MAX_LEN];
    end
    if (accept) begin
      case (op)
        OP_CLEAR: begin
          ref_len_nxt = '0;
          qcount_nxt  = '0;
          ovf_nxt     = 1'b0;
          dist_nxt    = '0;
        end
        OP_APPEND_REF: begin
          if (qcount_r == '0) begin
            if (ref_len_r == DP_W'(MAX_LEN)) begin
              ovf_nxt = 1'b1;
            end else begin
              ref_len_nxt = ref_len_r + 1'b1;
              dist_nxt    = ref_len_r + 1'b1;
            end
          end
        end
        OP_APPEND_QRY: begin
          if (qcount_r == DP_W'(MAX_LEN)) begin
            ovf_nxt = 1'b1;
          end else begin
            qcount_nxt = qcount_r + 1'b1;
          end
        end
        OP_FINISH: begin
          qcount_nxt = '0;
          dist_nxt   = ref_len_r;
        end
        default: begin
          qcount_nxt = qcount_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_len_r   <= '0;
      qcount_r    <= '0;
      ovf_r       <= 1'b0;
      dist_r      <= '0;
      wv0_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ref_len_r   <= ref_len_nxt;
      qcount_r    <= qcount_nxt;
      ovf_r       <= ovf_nxt;
      dist_r      <= dist_nxt;
      wv0_vld_r   <= launch;
      out_valid_r <= accept && (op == OP_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    wv0_ch_r       <= in_char_in;
    wv0_left_r     <= qcount_r + 1'b1;
    wv0_diag_r     <= qcount_r;
    out_distance_r <= dist_r[DIST_W-1:0];
    out_overflow_r <= ovf_r;
  end

  assign wv_vld[0]  = wv0_vld_r;
  assign wv_ch[0]   = wv0_ch_r;
  assign wv_left[0] = wv0_left_r;
  assign wv_diag[0] = wv0_diag_r;

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    edi_cell #(
      .DP_W (DP_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .cell_idx  (DP_W'(k + 1)),
      .ref_len   (ref_len_r),
      .wv_vld_i  (wv_vld[k]),
      .wv_ch_i   (wv_ch[k]),
      .wv_left_i (wv_left[k]),
      .wv_diag_i (wv_diag[k]),
      .wv_vld_o  (wv_vld[k+1]),
      .wv_ch_o   (wv_ch[k+1]),
      .wv_left_o (wv_left[k+1]),
      .wv_diag_o (wv_diag[k+1])
    );
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_overflow = out_overflow_r;

  // The result strobe follows a finish transfer, and nothing else.
  `EDI_ASSERT_NEXT(a_finish_gives_result, clk, rst_n, accept && (op == OP_FINISH), out_valid)
  `EDI_ASSERT_IMPLY(a_result_from_finish, clk, rst_n, out_valid,
                    $past(start && !busy && (in_opcode == OP_FINISH)))
  // A query byte that is not dropped keeps the block busy while its wavefront runs.
  `EDI_ASSERT_NEXT(a_launch_busy, clk, rst_n, launch, busy && (qcount_r != '0))
  // The overflow flag is sticky until a clear.
  `EDI_ASSERT_IMPLY(a_overflow_sticky, clk, rst_n, $fell(ovf_r) && $past(rst_n),
                    $past(start && !busy && (in_opcode == OP_CLEAR)))
  `EDI_ASSERT_IMPLY(a_counts_in_range, clk, rst_n, 1'b1,
                    (ref_len_r <= DP_W'(MAX_LEN)) && (qcount_r <= DP_W'(MAX_LEN)))

endmodule

// ----- verif/edit_distance_engine_checker.sv -----
// ----------------------------------------------------------------------------
// Edit distance engine checker
// Watches the command and result channels of the engine and keeps its own
// copy of the reference string, the distance column and the overflow flag.
// Every finish predicts a distance, and each result is compared field by
// field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edit_distance_engine_checker #(
  parameter int MAX_LEN = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [1:0]                    in_opcode,
  input  logic [edi_pkg::CHAR_W-1:0]    in_char_in,
  input  logic                          out_valid,
  input  logic [edi_pkg::DIST_W-1:0]    out_distance,
  input  logic                          out_overflow,
  output int unsigned                   failures,
  output int unsigned                   results_due
);
  import edi_pkg::*;

  typedef struct {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } score_t;

  score_t            distances_due[$];
  score_t            want;
  score_t            got;
  logic [CHAR_W-1:0] ref_str [MAX_LEN];
  logic [DIST_W-1:0] ref_len;
  logic [DIST_W-1:0] qry_len;
  logic [DIST_W:0]   column [MAX_LEN+1];
  logic              ovf;
  int unsigned       fail_count = 0;

  assign failures = fail_count;

  function automatic void reset_column();
    for (int i = 0; i <= MAX_LEN; i++) column[i] = (DIST_W+1)'(i);
    qry_len = '0;
  endfunction

  function automatic void wipe_all();
    for (int i = 0; i < MAX_LEN; i++) ref_str[i] = '0;
    ref_len = '0;
    ovf     = 1'b0;
    reset_column();
  endfunction

  function automatic void sweep_column(logic [CHAR_W-1:0] ch);
    logic [DIST_W:0] diag;
    logic [DIST_W:0] above;
    logic [DIST_W:0] best;
    diag      = column[0];
    column[0] = qry_len + 1'b1;
    for (int i = 1; i <= ref_len; i++) begin
      above = column[i];
      if (ref_str[i-1] == ch) begin
        column[i] = diag;
      end else begin
        best = above;
        if (column[i-1] < best) best = column[i-1];
        if (diag < best) best = diag;
        column[i] = best + 1'b1;
      end
      diag = above;
    end
    qry_len++;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      wipe_all();
      distances_due.delete();
    end else begin
      if (out_valid !== 1'b0) begin
        got.distance = out_distance;
        got.overflow = out_overflow;
        if (distances_due.size() == 0) begin
          fail_count++;
          $display("%0t: result with none expected, got distance %0d overflow %0b",
                   $time, got.distance, got.overflow);
        end else begin
          want = distances_due.pop_front();
          if (got.distance !== want.distance) begin
            fail_count++;
            $display("%0t: distance expected %0d, got %0d",
                     $time, want.distance, got.distance);
          end
          if (got.overflow !== want.overflow) begin
            fail_count++;
            $display("%0t: overflow expected %0b, got %0b",
                     $time, want.overflow, got.overflow);
          end
        end
      end
      if (start && !busy) begin
        case (in_opcode)
          OP_CLEAR: begin
            wipe_all();
          end
          OP_APPEND_REF: begin
            if (qry_len == 0) begin
              if (ref_len >= MAX_LEN) begin
                ovf = 1'b1;
              end else begin
                ref_str[ref_len] = in_char_in;
                ref_len++;
              end
            end
          end
          OP_APPEND_QRY: begin
            if (qry_len >= MAX_LEN) ovf = 1'b1;
            else sweep_column(in_char_in);
          end
          default: begin
            want.distance = column[ref_len][DIST_W-1:0];
            want.overflow = ovf;
            distances_due.push_back(want);
            reset_column();
          end
        endcase
      end
    end
    results_due <= distances_due.size();
  end

endmodule

// ----- verif/edit_distance_engine_test.sv -----
// ----------------------------------------------------------------------------
// Edit distance engine testbench
// Drives clear, reference, query and finish commands into the engine with
// random gaps, first a short directed sequence and then random sessions of
// reference and query strings over a small alphabet, with noise in between.
// The checker beside the engine predicts and compares every distance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edit_distance_engine_test;
  import edi_pkg::*;

  localparam int MAX_LEN     = 16;
  localparam int ITEM_TARGET = 1900;
  localparam int STALL_LIMIT = 1000;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_opcode;
  logic [CHAR_W-1:0] in_char_in;
  logic              out_valid;
  logic [DIST_W-1:0] out_distance;
  logic              out_overflow;
  int unsigned       failures;
  int unsigned       results_due;
  int unsigned       items_sent = 0;
  int unsigned       quiet_cycles = 0;
  logic              steady = 1'b0;

  edit_distance_engine #(
    .MAX_LEN(MAX_LEN)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_opcode   (in_opcode),
    .in_char_in  (in_char_in),
    .out_valid   (out_valid),
    .out_distance(out_distance),
    .out_overflow(out_overflow)
  );

  edit_distance_engine_checker #(
    .MAX_LEN(MAX_LEN)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_opcode   (in_opcode),
    .in_char_in  (in_char_in),
    .out_valid   (out_valid),
    .out_distance(out_distance),
    .out_overflow(out_overflow),
    .failures    (failures),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [CHAR_W-1:0] pick_char();
    logic [CHAR_W-1:0] ch;
    ch = 8'h61 + 8'($urandom_range(2));
    if ($urandom_range(7) == 0) ch = ch ^ 8'h20;
    if ($urandom_range(3) == 0) ch = 8'($urandom);
    return ch;
  endfunction

  function automatic int pick_len();
    if ($urandom_range(5) == 0) return $urandom_range(MAX_LEN + 2, MAX_LEN - 1);
    return $urandom_range(8);
  endfunction

  // Returns at the edge where the command is transferred, with start still high.
  task automatic send(op_t op, logic [CHAR_W-1:0] ch);
    if (!steady && $urandom_range(99) < 33) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 33);
    end
    start      <= 1'b1;
    in_opcode  <= op;
    in_char_in <= ch;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic run_session();
    int n_ref;
    int n_qry;
    int n_runs;
    if ($urandom_range(5) == 0) begin
      repeat ($urandom_range(6, 1)) send(op_t'($urandom_range(3)), 8'($urandom));
    end
    if ($urandom_range(3) != 0) send(OP_CLEAR, 8'($urandom));
    n_ref = pick_len();
    for (int i = 0; i < n_ref; i++) send(OP_APPEND_REF, pick_char());
    n_runs = $urandom_range(4, 1);
    for (int r = 0; r < n_runs; r++) begin
      n_qry = pick_len();
      for (int i = 0; i < n_qry; i++) begin
        if (i > 0 && $urandom_range(19) == 0) send(OP_APPEND_REF, pick_char());
        send(OP_APPEND_QRY, pick_char());
      end
      send(OP_FINISH, 8'($urandom));
    end
    if ($urandom_range(9) == 0) drain();
  endtask

  initial begin
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_opcode  <= OP_CLEAR;
    in_char_in <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(OP_CLEAR, 8'hFF);
    send(OP_FINISH, 8'hFF);
    send(OP_APPEND_REF, 8'h00);
    send(OP_APPEND_REF, 8'hFF);
    send(OP_APPEND_REF, 8'h61);
    send(OP_APPEND_REF, 8'h41);
    send(OP_FINISH, 8'h00);
    send(OP_APPEND_QRY, 8'h41);
    send(OP_APPEND_REF, 8'h55);
    send(OP_APPEND_QRY, 8'hFF);
    send(OP_APPEND_QRY, 8'h61);
    send(OP_FINISH, 8'h00);
    send(OP_CLEAR, 8'h00);
    send(OP_APPEND_QRY, 8'h61);
    send(OP_APPEND_QRY, 8'h00);
    send(OP_FINISH, 8'h00);
    drain();

    while (items_sent < ITEM_TARGET) begin
      steady = (items_sent > 700 && items_sent < 1000);
      run_session();
    end

    drain();
    repeat (MAX_LEN + 4) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
